@@ design/ipv4ep_pkg.sv @@
// ipv4ep_pkg: shared types and constants for the ipv4 endpoint text validator
// no dependencies; used by ipv4ep_step and ipv4_endpoint_text_validator

package ipv4ep_pkg;

    // field and value widths
    localparam int CharWidth   = 8;
    localparam int ValueWidth  = 17;
    localparam int PhaseWidth  = 3;
    localparam int ProdWidth   = 20;
    localparam int DigitWidth  = 4;

    // character codes
    localparam logic [CharWidth-1:0] CH_COLON = 8'h3A;
    localparam logic [CharWidth-1:0] CH_DOT   = 8'h2E;
    localparam logic [CharWidth-1:0] CH_ZERO  = 8'h30;
    localparam logic [CharWidth-1:0] CH_NINE  = 8'h39;

    // field limits
    localparam logic [ValueWidth-1:0] OCTET_MAX = 17'd255;
    localparam logic [ValueWidth-1:0] PORT_MAX  = 17'd65535;
    localparam logic [ValueWidth-1:0] VALUE_SAT = 17'd65536;

    // phase codes: octets 0..3, then the port
    localparam logic [PhaseWidth-1:0] PHASE_OCT0 = 3'd0;
    localparam logic [PhaseWidth-1:0] PHASE_OCT3 = 3'd3;
    localparam logic [PhaseWidth-1:0] PHASE_PORT = 3'd4;

    // parser state carried from one character to the next
    typedef struct packed {
        logic [PhaseWidth-1:0] phase;
        logic [ValueWidth-1:0] field_value;
        logic                  field_nonempty;
        logic                  failed;
    } parse_state_t;

    localparam parse_state_t STATE_CLEAR = '{
        phase:          PHASE_OCT0,
        field_value:    '0,
        field_nonempty: 1'b0,
        failed:         1'b0
    };

endpackage

@@ design/ipv4ep_step.sv @@
// ipv4ep_step: next-state and verdict logic for one character of the string
// depends on ipv4ep_pkg

module ipv4ep_step (
    input  ipv4ep_pkg::parse_state_t            state_cur,
    input  logic [ipv4ep_pkg::CharWidth-1:0]    ch,
    input  logic                                has_char,
    input  logic                                last,
    output ipv4ep_pkg::parse_state_t            state_next,
    output logic                                valid_res
);

    logic                                 is_digit;
    logic [ipv4ep_pkg::DigitWidth-1:0]    digit;
    logic [ipv4ep_pkg::ProdWidth-1:0]     prod;
    logic [ipv4ep_pkg::ValueWidth-1:0]    acc_value;
    logic                                 octet_ok;
    ipv4ep_pkg::parse_state_t             after_char;

    // decimal accumulate with saturation
    assign is_digit = (ch >= ipv4ep_pkg::CH_ZERO) && (ch <= ipv4ep_pkg::CH_NINE);
    assign digit    = ipv4ep_pkg::DigitWidth'(ch - ipv4ep_pkg::CH_ZERO);
    assign prod     = ipv4ep_pkg::ProdWidth'(state_cur.field_value) * 20'd10
                    + ipv4ep_pkg::ProdWidth'(digit);
    assign acc_value = (prod > ipv4ep_pkg::ProdWidth'(ipv4ep_pkg::VALUE_SAT))
                     ? ipv4ep_pkg::VALUE_SAT : prod[ipv4ep_pkg::ValueWidth-1:0];

    assign octet_ok = state_cur.field_nonempty
                   && (state_cur.field_value <= ipv4ep_pkg::OCTET_MAX);

    // apply the character, if any
    always_comb begin
        after_char = state_cur;
        if (has_char && !state_cur.failed) begin
            priority if (is_digit) begin
                after_char.field_value    = acc_value;
                after_char.field_nonempty = 1'b1;
            end else if (((state_cur.phase < ipv4ep_pkg::PHASE_OCT3
                           && ch == ipv4ep_pkg::CH_DOT)
                          || (state_cur.phase == ipv4ep_pkg::PHASE_OCT3
                           && ch == ipv4ep_pkg::CH_COLON)) && octet_ok) begin
                after_char.phase          = state_cur.phase + 3'd1;
                after_char.field_value    = '0;
                after_char.field_nonempty = 1'b0;
            end else begin
                after_char.failed = 1'b1;
            end
        end
    end

    // verdict at end of string, then clear for the next one
    assign valid_res = !after_char.failed
                    && (after_char.phase == ipv4ep_pkg::PHASE_PORT)
                    && after_char.field_nonempty
                    && (after_char.field_value != '0)
                    && (after_char.field_value <= ipv4ep_pkg::PORT_MAX);

    assign state_next = last ? ipv4ep_pkg::STATE_CLEAR : after_char;

endmodule

@@ design/ipv4_endpoint_text_validator.sv @@
// ipv4_endpoint_text_validator: top level, checks a.b.c.d:port text streams
// depends on ipv4ep_pkg and ipv4ep_step
//
//  channel | direction | tdata            | tuser    | tlast
//  s_      | in        | [7:0] ch         | has_char | last
//  m_      | out       | [0] valid_res    | -        | -
//
// one character per cycle while no end-of-string item waits on a stalled result; a
// verdict for the transaction that carries last passes the input register, then the result register.
// the parser state lives in one register set updated by a single-level step,
// which sets the one-item-per-cycle pace.
// aresetn is synchronous, active low, and returns the parser to the first octet.
// a stalled result holds only items that carry last; other items keep flowing.

module ipv4_endpoint_text_validator (
    input  logic       aclk,
    input  logic       aresetn,
    // input stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] ch
    input  logic       s_tuser,   // [0] has_char
    input  logic       s_tlast,
    // result stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] valid_res, [7:1] zero
);

    logic                               s1_valid_reg;
    logic [ipv4ep_pkg::CharWidth-1:0]   s1_ch_reg;
    logic                               s1_has_char_reg;
    logic                               s1_last_reg;
    ipv4ep_pkg::parse_state_t           state_reg;
    ipv4ep_pkg::parse_state_t           state_next;
    logic                               verdict;
    logic                               m_valid_reg;
    logic                               m_res_reg;
    logic                               process_en;

    // a stage-one item moves on unless it needs the result slot and that is busy
    assign process_en = s1_valid_reg && (!s1_last_reg || !m_valid_reg || m_tready);
    assign s_tready   = !s1_valid_reg || process_en;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            s1_ch_reg       <= s_tdata;
            s1_has_char_reg <= s_tuser;
            s1_last_reg     <= s_tlast;
        end
    end

    ipv4ep_step u_step (
        .state_cur  (state_reg),
        .ch         (s1_ch_reg),
        .has_char   (s1_has_char_reg),
        .last       (s1_last_reg),
        .state_next (state_next),
        .valid_res  (verdict)
    );

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ipv4ep_pkg::STATE_CLEAR;
        end else if (process_en) begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (process_en && s1_last_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (process_en && s1_last_reg) begin
            m_res_reg <= verdict;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_res_reg};

`ifndef SYNTHESIS
    // end of string leaves the parser cleared
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        process_en && s1_last_reg |=> state_reg == ipv4ep_pkg::STATE_CLEAR)
        else $error("parser state not cleared after end of string");

    // a new result only comes from a processed end-of-string item
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(process_en && s1_last_reg))
        else $error("result without end-of-string item");

    // phase never goes beyond the port field
    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.phase <= ipv4ep_pkg::PHASE_PORT)
        else $error("phase out of range");

    // running value stays at or below the saturation point
    a_value_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.field_value <= ipv4ep_pkg::VALUE_SAT)
        else $error("field value beyond saturation");

    // a blocked input side means a held end-of-string item facing a stalled result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> s1_valid_reg && s1_last_reg && m_valid_reg && !m_tready)
        else $error("input stalled without cause");
`endif

endmodule

@@ tb/ipv4_endpoint_text_validator_tb.sv @@
`timescale 1ns / 1ps
// ipv4_endpoint_text_validator_tb: self-checking stream testbench for the endpoint text validator
// depends on ipv4ep_pkg and ipv4_endpoint_text_validator; predicts each verdict per character

module ipv4_endpoint_text_validator_tb;

    // one input transaction: character, has_char flag, end of string
    typedef struct packed {
        logic [ipv4ep_pkg::CharWidth-1:0] ch;
        logic                             has_char;
        logic                             last;
    } char_item_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tuser  = 1'b0;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;

    char_item_t                pending[$];
    logic                      verdicts[$];
    byte unsigned              text_buf[$];
    ipv4ep_pkg::parse_state_t  parser = ipv4ep_pkg::STATE_CLEAR;
    int             send_idle_pct  = 0;
    int             recv_stall_pct = 0;
    int             hold_reqs      = 0;
    int             hold_taken     = 0;
    int             hold_left      = 0;
    int             mismatches     = 0;
    int             char_count     = 0;

    ipv4_endpoint_text_validator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // [7:0] ch
        .s_tuser  (s_tuser),    // [0] has_char
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)     // [0] valid_res, [7:1] zero
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // advance the parser by one accepted transaction, queue a verdict on last
    task automatic predict_item(input logic [7:0] c, input logic has_c, input logic is_last);
        int unsigned acc;
        logic        octet_good;
        logic        verdict_now;
        if (has_c && !parser.failed) begin
            octet_good = parser.field_nonempty
                      && (parser.field_value <= ipv4ep_pkg::OCTET_MAX);
            if (c >= ipv4ep_pkg::CH_ZERO && c <= ipv4ep_pkg::CH_NINE) begin
                acc = int'(parser.field_value) * 10 + int'(c - ipv4ep_pkg::CH_ZERO);
                parser.field_value    = (acc > ipv4ep_pkg::VALUE_SAT)
                                      ? ipv4ep_pkg::VALUE_SAT
                                      : acc[ipv4ep_pkg::ValueWidth-1:0];
                parser.field_nonempty = 1'b1;
            end else if ((parser.phase < ipv4ep_pkg::PHASE_OCT3
                          && c == ipv4ep_pkg::CH_DOT && octet_good) ||
                         (parser.phase == ipv4ep_pkg::PHASE_OCT3
                          && c == ipv4ep_pkg::CH_COLON && octet_good)) begin
                parser.phase          = parser.phase + 1'b1;
                parser.field_value    = '0;
                parser.field_nonempty = 1'b0;
            end else begin
                parser.failed = 1'b1;
            end
        end
        if (is_last) begin
            verdict_now = !parser.failed && parser.phase == ipv4ep_pkg::PHASE_PORT &&
                          parser.field_nonempty && parser.field_value >= 17'd1 &&
                          parser.field_value <= ipv4ep_pkg::PORT_MAX;
            verdicts.insert(verdicts.size(), verdict_now);
            parser = ipv4ep_pkg::STATE_CLEAR;
        end
    endtask

    // driver: present queued items, predict on each accepted transaction
    always @(posedge aclk) begin
        char_item_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                predict_item(s_tdata, s_tuser, s_tlast);
            if (!s_tvalid || s_tready) begin
                if (pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = pending.pop_front();
                    s_tdata  <= nxt.ch;
                    s_tuser  <= nxt.has_char;
                    s_tlast  <= nxt.last;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver ready, with long hold-offs on request
    always @(posedge aclk) begin
        if (hold_reqs != hold_taken) begin
            hold_taken <= hold_reqs;
            hold_left  <= 400;
            m_tready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // monitor: compare every result transaction with the oldest verdict
    always @(posedge aclk) begin
        logic exp_valid;
        if (aresetn && m_tvalid && m_tready) begin
            if (verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: tdata %h", m_tdata);
            end else begin
                exp_valid = verdicts.pop_front();
                if (m_tdata !== {7'b0, exp_valid}) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("verdict mismatch: expected %h actual %h",
                                 {7'b0, exp_valid}, m_tdata);
                end
            end
        end
    end

    // stimulus helpers
    task automatic put_text(input byte unsigned b);
        text_buf.insert(text_buf.size(), b);
    endtask

    task automatic put_item(input char_item_t it);
        pending.insert(pending.size(), it);
        char_count++;
    endtask

    task automatic push_char(input byte unsigned c, input bit is_last);
        put_item('{ch: c, has_char: 1'b1, last: is_last});
    endtask

    task automatic push_marker();
        put_item('{ch: 8'($urandom_range(0, 255)), has_char: 1'b0, last: 1'b1});
    endtask

    task automatic push_idle();
        put_item('{ch: 8'($urandom_range(0, 255)), has_char: 1'b0, last: 1'b0});
    endtask

    // decimal text of a value, sometimes with leading zeros
    task automatic append_dec(input longint unsigned v, input int zeros);
        string s;
        s = $sformatf("%0d", v);
        repeat (zeros) put_text(ipv4ep_pkg::CH_ZERO);
        for (int i = 0; i < s.len(); i++)
            put_text(s[i]);
    endtask

    function automatic int lead_zeros();
        return ($urandom_range(0, 99) < 15) ? $urandom_range(1, 2) : 0;
    endfunction

    function automatic longint unsigned pick_octet();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 255;
            2: return 256;
            3: return $urandom_range(256, 999);
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function automatic longint unsigned pick_port();
        case ($urandom_range(0, 11))
            0: return 0;
            1: return 1;
            2: return 65535;
            3: return 65536;
            4: return 65537;
            5: return 64'd99999999999;
            6: return $urandom_range(0, 99);
            default: return $urandom_range(1, 65535);
        endcase
    endfunction

    // send the text buffer, ending on its last character or a separate end marker
    task automatic send_text();
        bit marker_end;
        marker_end = (text_buf.size() == 0) || ($urandom_range(0, 99) < 40);
        foreach (text_buf[i]) begin
            if ($urandom_range(0, 99) < 8)
                push_idle();
            push_char(text_buf[i], !marker_end && i == text_buf.size() - 1);
        end
        if (marker_end)
            push_marker();
        text_buf.delete();
    endtask

    // mostly well-formed endpoints, some with one defect
    task automatic gen_endpoint();
        int defect;
        int n_oct;
        int gap;
        int pos;
        defect = ($urandom_range(0, 99) < 30) ? $urandom_range(0, 6) : 7;
        n_oct  = (defect == 0) ? 3 : (defect == 1) ? 5 : 4;
        gap    = $urandom_range(0, n_oct - 1);
        for (int i = 0; i < n_oct; i++) begin
            if (i != 0)
                put_text(ipv4ep_pkg::CH_DOT);
            if (!(defect == 2 && i == gap))
                append_dec(pick_octet(), lead_zeros());
        end
        // no colon: the port digits run on into the fourth octet or follow a dot
        if (defect == 3) begin
            if ($urandom_range(0, 1))
                put_text(ipv4ep_pkg::CH_DOT);
        end else begin
            put_text(ipv4ep_pkg::CH_COLON);
        end
        if (defect != 4)
            append_dec(pick_port(), lead_zeros());
        if (defect == 5) begin
            put_text(ipv4ep_pkg::CH_COLON);
            append_dec($urandom_range(1, 65535), 0);
        end
        if (defect == 6) begin
            pos = $urandom_range(0, text_buf.size() - 1);
            if ($urandom_range(0, 1))
                text_buf[pos] = 8'($urandom_range(0, 255));
            else
                text_buf.insert(pos, 8'($urandom_range(0, 255)));
        end
        send_text();
    endtask

    // short runs of arbitrary characters
    task automatic gen_noise();
        int len;
        len = $urandom_range(0, 10);
        repeat (len) begin
            case ($urandom_range(0, 3))
                0: put_text(8'($urandom_range(ipv4ep_pkg::CH_ZERO, ipv4ep_pkg::CH_NINE)));
                1: put_text(ipv4ep_pkg::CH_DOT);
                2: put_text(ipv4ep_pkg::CH_COLON);
                default: put_text(8'($urandom_range(0, 255)));
            endcase
        end
        send_text();
    endtask

    task automatic wait_sent();
        while (pending.size() != 0 || s_tvalid)
            @(posedge aclk);
    endtask

    // main sequence
    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: largest octets and port, then end marker
        repeat (4) begin
            append_dec(255, 0);
            put_text(ipv4ep_pkg::CH_DOT);
        end
        text_buf[text_buf.size() - 1] = ipv4ep_pkg::CH_COLON;
        append_dec(65535, 0);
        foreach (text_buf[i])
            push_char(text_buf[i], 1'b0);
        text_buf.delete();
        push_marker();
        // idle item, lone end marker, then a nul character carrying last
        put_item('{ch: 8'hFF, has_char: 1'b0, last: 1'b0});
        put_item('{ch: 8'hFF, has_char: 1'b0, last: 1'b1});
        push_char(8'h00, 1'b1);
        wait_sent();

        // random phases: no idling (with one long receiver hold-off), sender idle, receiver stalls, both
        for (int mode = 0; mode < 4; mode++) begin
            case (mode)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            if (mode == 0)
                hold_reqs++;
            while (char_count < 25 + (mode + 1) * 232) begin
                if ($urandom_range(0, 99) < 80)
                    gen_endpoint();
                else
                    gen_noise();
            end
            wait_sent();
        end

        // drain outstanding verdicts, then allow for pipeline latency
        while (verdicts.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && verdicts.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2ms;
        $display("Some tests failed");
        $finish;
    end

endmodule

@@ ipv4_endpoint_text_validator.f @@
design/ipv4ep_pkg.sv
design/ipv4ep_step.sv
design/ipv4_endpoint_text_validator.sv
tb/ipv4_endpoint_text_validator_tb.sv
